[design/dsr_pkg.sv]
// shared constants and codes for the dense slot table swap-remove unit
package dsr_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned ID_BITS  = 12;

  localparam int unsigned ID_W     = 12;
  localparam int unsigned OUT_W    = 11;
  localparam int unsigned ROW_W    = $clog2(CAPACITY + 1);
  localparam int unsigned ENT_AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned ID_SPACE = 1 << ID_BITS;

  localparam logic [1:0] FUNC_FIND   = 2'd0;
  localparam logic [1:0] FUNC_ADD    = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_PRESENT   = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

endpackage

[design/dense_slot_table_swap_remove_unit.sv]
// top level of the dense slot table swap-remove unit
//
// Command channel: func_i and entity_id_i are taken at a rising edge where
// start is high and busy is low. Result channel: done_o is high for exactly
// one cycle with row_index_o, moved_from_o, status_o and live_count_o; the
// receiver cannot hold it off, and the result registers are independent of
// the command side, so a new command may be taken while a result is shown.
// Find and add do the map and last-row reads, then decide and write in S_EXEC,
// and the result shows in the cycle after; a new command may be taken from
// the cycle in which the result shows. A successful remove adds a second
// write state, S_REM2, since the row-of-entity map has one write port:
// the moved entity is remapped, then the removed one is unmapped.
// After reset the row-of-entity map is cleared one entry per cycle, all 4096
// entries (2^ID_BITS), with busy high; the row table needs no clearing since
// only the contents of occupied rows are ever used.
module dense_slot_table_swap_remove_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 func_i,
  input  logic [dsr_pkg::ID_W-1:0]   entity_id_i,
  output logic                       done_o,
  output logic [dsr_pkg::OUT_W-1:0]  row_index_o,
  output logic [dsr_pkg::OUT_W-1:0]  moved_from_o,
  output logic [1:0]                 status_o,
  output logic [dsr_pkg::OUT_W-1:0]  live_count_o
);
  import dsr_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_REM2
  } state_e;

  state_e             state_q;
  logic [ID_BITS-1:0] clr_q;
  logic [1:0]         func_q;
  logic [ID_BITS-1:0] id_q;
  logic [ROW_W-1:0]   count_q;
  logic [ROW_W-1:0]   row_q;
  logic               done_q;
  logic [OUT_W-1:0]   row_index_q;
  logic [OUT_W-1:0]   moved_from_q;
  status_e            status_q;
  logic [OUT_W-1:0]   live_count_q;

  logic               accept;
  logic               map_we;
  logic [ID_BITS-1:0] map_waddr;
  logic [ROW_W-1:0]   map_wdata;
  logic [ROW_W-1:0]   map_rdata;
  logic               ent_we;
  logic [ENT_AW-1:0]  ent_waddr;
  logic [ID_BITS-1:0] ent_wdata;
  logic [ID_BITS-1:0] ent_rdata;
  logic [ROW_W-1:0]   count_m1;
  logic [ROW_W-1:0]   count_p1;
  logic [ROW_W-1:0]   row_m1;
  logic               found;
  logic               add_ok;
  logic               rem_ok;

  assign accept   = start && (state_q == S_IDLE);
  assign busy     = (state_q != S_IDLE);
  assign count_m1 = count_q - ROW_W'(1);
  assign count_p1 = count_q + ROW_W'(1);
  assign row_m1   = map_rdata - ROW_W'(1);
  assign found    = (map_rdata != '0);
  assign add_ok   = (func_q == FUNC_ADD) && !found && (count_q < ROW_W'(CAPACITY));
  assign rem_ok   = (func_q == FUNC_REMOVE) && found && (map_rdata <= count_q)
                    && (count_q != '0);

  dsr_ram #(
    .DEPTH (ID_SPACE),
    .WIDTH (ROW_W)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (accept),
    .raddr_i (entity_id_i[ID_BITS-1:0]),
    .rdata_o (map_rdata)
  );

  dsr_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ID_BITS)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (accept),
    .raddr_i (count_m1[ENT_AW-1:0]),
    .rdata_o (ent_rdata)
  );

  always_comb begin
    map_we    = 1'b0;
    map_waddr = id_q;
    map_wdata = '0;
    ent_we    = 1'b0;
    ent_waddr = count_q[ENT_AW-1:0];
    ent_wdata = id_q;
    unique case (state_q)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_q;
      end
      S_EXEC: begin
        if (add_ok) begin
          map_we    = 1'b1;
          map_wdata = count_p1;
          ent_we    = 1'b1;
        end else if (rem_ok) begin
          // move last entity into the hole
          map_we    = 1'b1;
          map_waddr = ent_rdata;
          map_wdata = map_rdata;
          ent_we    = 1'b1;
          ent_waddr = row_m1[ENT_AW-1:0];
          ent_wdata = ent_rdata;
        end
      end
      S_REM2: begin
        map_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      count_q      <= '0;
      done_q       <= 1'b0;
      func_q       <= FUNC_FIND;
      id_q         <= '0;
      row_q        <= '0;
      row_index_q  <= '0;
      moved_from_q <= '0;
      status_q     <= ST_OK;
      live_count_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + ID_BITS'(1);
          if (clr_q == '1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            func_q  <= func_i;
            id_q    <= entity_id_i[ID_BITS-1:0];
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q      <= S_IDLE;
          done_q       <= 1'b1;
          moved_from_q <= '0;
          live_count_q <= OUT_W'(count_q);
          unique case (func_q)
            FUNC_ADD: begin
              if (found) begin
                row_index_q <= OUT_W'(map_rdata);
                status_q    <= ST_PRESENT;
              end else if (!add_ok) begin
                row_index_q <= '0;
                status_q    <= ST_FULL;
              end else begin
                count_q      <= count_p1;
                row_index_q  <= OUT_W'(count_p1);
                live_count_q <= OUT_W'(count_p1);
                status_q     <= ST_OK;
              end
            end
            FUNC_REMOVE: begin
              if (rem_ok) begin
                row_q   <= map_rdata;
                done_q  <= 1'b0;
                state_q <= S_REM2;
              end else begin
                row_index_q <= '0;
                status_q    <= ST_NOT_FOUND;
              end
            end
            default: begin
              row_index_q <= OUT_W'(map_rdata);
              status_q    <= found ? ST_OK : ST_NOT_FOUND;
            end
          endcase
        end
        S_REM2: begin
          state_q      <= S_IDLE;
          done_q       <= 1'b1;
          count_q      <= count_m1;
          row_index_q  <= OUT_W'(row_q);
          moved_from_q <= OUT_W'(count_q);
          status_q     <= ST_OK;
          live_count_q <= OUT_W'(count_m1);
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o       = done_q;
  assign row_index_o  = row_index_q;
  assign moved_from_o = moved_from_q;
  assign status_o     = status_q;
  assign live_count_o = live_count_q;

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ROW_W'(CAPACITY))
    else $error("live count above capacity");

  a_single_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_remove_rows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && moved_from_o != '0) |->
      (row_index_o != '0 && row_index_o <= moved_from_o && status_o == ST_OK))
    else $error("remove result rows inconsistent");

  a_remove_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REM2) |=> (done_o && live_count_o == $past(OUT_W'(count_m1))))
    else $error("remove did not shrink the table by one");

endmodule

[design/dsr_ram.sv]
// simple dual-port synchronous ram, one write and one registered read port
module dsr_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[test/tb_dense_slot_table_swap_remove_unit.sv]
// self-checking testbench for the dense slot table swap-remove unit
`timescale 1ns / 100ps

module tb_dense_slot_table_swap_remove_unit;
  import dsr_pkg::*;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DIRECTED_N = 21;
  localparam int unsigned PRINT_CAP = 40;

  typedef struct packed {
    logic [OUT_W-1:0] row;
    logic [OUT_W-1:0] moved;
    status_e          status;
    logic [OUT_W-1:0] count;
  } table_outcome_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [ID_W-1:0]  id;
    bit               typed;
    logic [OUT_W-1:0] row;
    logic [OUT_W-1:0] moved;
    status_e          status;
    logic [OUT_W-1:0] count;
  } step_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [1:0]       func_i;
  logic [ID_W-1:0]  entity_id_i;
  logic             done_o;
  logic [OUT_W-1:0] row_index_o;
  logic [OUT_W-1:0] moved_from_o;
  logic [1:0]       status_o;
  logic [OUT_W-1:0] live_count_o;

  logic [OUT_W-1:0] row_of_id [ID_SPACE];
  logic [ID_W-1:0]  id_at_row [CAPACITY+1];
  int unsigned      live_rows;
  table_outcome_t   pending_outcomes [$];
  int unsigned      mismatch_count;
  int unsigned      cycle_count;
  int unsigned      burst_left;

  // special cases: empty table, unused code, present add, swap and last-row removes
  step_row_t directed_steps [DIRECTED_N] = '{
    '{FUNC_FIND,   12'd0,    1'b1, 11'd0, 11'd0, ST_NOT_FOUND, 11'd0},
    '{FUNC_FIND,   12'd4095, 1'b1, 11'd0, 11'd0, ST_NOT_FOUND, 11'd0},
    '{FUNC_REMOVE, 12'd4095, 1'b1, 11'd0, 11'd0, ST_NOT_FOUND, 11'd0},
    '{FUNC_SPARE,  12'd5,    1'b1, 11'd0, 11'd0, ST_NOT_FOUND, 11'd0},
    '{FUNC_ADD,    12'd0,    1'b1, 11'd1, 11'd0, ST_OK,        11'd1},
    '{FUNC_ADD,    12'd4095, 1'b1, 11'd2, 11'd0, ST_OK,        11'd2},
    '{FUNC_ADD,    12'd0,    1'b1, 11'd1, 11'd0, ST_PRESENT,   11'd2},
    '{FUNC_FIND,   12'd4095, 1'b1, 11'd2, 11'd0, ST_OK,        11'd2},
    '{FUNC_SPARE,  12'd4095, 1'b1, 11'd2, 11'd0, ST_OK,        11'd2},
    '{FUNC_ADD,    12'hAAA,  1'b1, 11'd3, 11'd0, ST_OK,        11'd3},
    '{FUNC_ADD,    12'h555,  1'b1, 11'd4, 11'd0, ST_OK,        11'd4},
    '{FUNC_REMOVE, 12'd0,    1'b0, 11'd0, 11'd0, ST_OK,        11'd0},
    '{FUNC_FIND,   12'h555,  1'b0, 11'd0, 11'd0, ST_OK,        11'd0},
    '{FUNC_FIND,   12'd0,    1'b1, 11'd0, 11'd0, ST_NOT_FOUND, 11'd3},
    '{FUNC_REMOVE, 12'd0,    1'b1, 11'd0, 11'd0, ST_NOT_FOUND, 11'd3},
    '{FUNC_REMOVE, 12'hAAA,  1'b0, 11'd0, 11'd0, ST_OK,        11'd0},
    '{FUNC_FIND,   12'hAAA,  1'b1, 11'd0, 11'd0, ST_NOT_FOUND, 11'd2},
    '{FUNC_REMOVE, 12'h555,  1'b0, 11'd0, 11'd0, ST_OK,        11'd0},
    '{FUNC_REMOVE, 12'd4095, 1'b0, 11'd0, 11'd0, ST_OK,        11'd0},
    '{FUNC_ADD,    12'd1,    1'b0, 11'd0, 11'd0, ST_OK,        11'd0},
    '{FUNC_REMOVE, 12'd1,    1'b1, 11'd1, 11'd1, ST_OK,        11'd0}
  };

  dense_slot_table_swap_remove_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .entity_id_i  (entity_id_i),
    .done_o       (done_o),
    .row_index_o  (row_index_o),
    .moved_from_o (moved_from_o),
    .status_o     (status_o),
    .live_count_o (live_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic note_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
    mismatch_count++;
  endtask

  task automatic apply_table_op(input logic [1:0] op, input logic [ID_W-1:0] raw_id,
                                output table_outcome_t outcome);
    logic [ID_W-1:0]  id;
    logic [ID_W-1:0]  tail_id;
    logic [OUT_W-1:0] row;
    int unsigned      tail_row;
    id = raw_id & ID_W'(ID_SPACE - 1);
    row = row_of_id[id];
    outcome = '{row: row, moved: '0, status: ST_OK, count: '0};
    case (op)
      FUNC_ADD: begin
        if (row != 0) begin
          outcome.status = ST_PRESENT;
        end else if (live_rows >= CAPACITY) begin
          outcome.status = ST_FULL;
        end else begin
          live_rows++;
          row_of_id[id] = OUT_W'(live_rows);
          id_at_row[live_rows] = id;
          outcome.row = OUT_W'(live_rows);
        end
      end
      FUNC_REMOVE: begin
        if (row == 0 || row > live_rows || live_rows == 0) begin
          outcome.row = '0;
          outcome.status = ST_NOT_FOUND;
        end else begin
          tail_row = live_rows;
          tail_id = id_at_row[tail_row];
          row_of_id[tail_id] = row;
          row_of_id[id] = '0;
          id_at_row[row] = tail_id;
          live_rows--;
          outcome.moved = OUT_W'(tail_row);
        end
      end
      default: begin
        if (row == 0) outcome.status = ST_NOT_FOUND;
      end
    endcase
    outcome.count = OUT_W'(live_rows);
  endtask

  // one command beat; returns in the time step of the accepting edge
  task automatic send_beat(input logic [1:0] op, input logic [ID_W-1:0] id,
                           input bit typed, input table_outcome_t typed_want);
    table_outcome_t predicted;
    start <= 1'b1;
    func_i <= op;
    entity_id_i <= id;
    do @(posedge clk_i); while (busy !== 1'b0);
    apply_table_op(op, id, predicted);
    pending_outcomes.push_back(typed ? typed_want : predicted);
    burst_left--;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 4))
        @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
  endtask

  function automatic logic [ID_W-1:0] any_id();
    return ID_W'($urandom_range(0, ID_SPACE - 1));
  endfunction

  function automatic logic [ID_W-1:0] live_id();
    if (live_rows == 0) return any_id();
    return id_at_row[$urandom_range(1, live_rows)];
  endfunction

  task automatic issue_random(input int unsigned add_pct, input int unsigned remove_pct);
    int unsigned    pick;
    logic [1:0]     op;
    logic [ID_W-1:0] id;
    pick = $urandom_range(0, 99);
    if (pick < add_pct) begin
      op = FUNC_ADD;
      id = ($urandom_range(0, 19) == 0) ? live_id() : any_id();
    end else if (pick < add_pct + remove_pct) begin
      op = FUNC_REMOVE;
      id = ($urandom_range(0, 9) != 0) ? live_id() : any_id();
    end else if (pick < 97) begin
      op = FUNC_FIND;
      id = ($urandom_range(0, 9) < 7) ? live_id() : any_id();
    end else begin
      op = FUNC_SPARE;
      id = ($urandom_range(0, 1) == 0) ? live_id() : any_id();
    end
    send_beat(op, id, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    table_outcome_t want;
    if (rst_ni === 1'b1 && done_o !== 1'b0) begin
      if (pending_outcomes.size() == 0) begin
        note_mismatch("result beat with nothing expected");
      end else begin
        want = pending_outcomes.pop_front();
        if (row_index_o !== want.row)
          note_mismatch($sformatf("row_index got %0d want %0d", row_index_o, want.row));
        if (moved_from_o !== want.moved)
          note_mismatch($sformatf("moved_from got %0d want %0d", moved_from_o, want.moved));
        if (status_o !== want.status)
          note_mismatch($sformatf("status got %0d want %s", status_o, want.status.name()));
        if (live_count_o !== want.count)
          note_mismatch($sformatf("live_count got %0d want %0d", live_count_o, want.count));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("dense_slot_table_swap_remove_unit verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned k;
    table_outcome_t typed_want;
    start <= 1'b0;
    func_i <= FUNC_FIND;
    entity_id_i <= '0;
    rst_ni <= 1'b0;
    cycle_count <= 0;
    mismatch_count = 0;
    live_rows = 0;
    for (k = 0; k < ID_SPACE; k++) row_of_id[k] = '0;
    for (k = 0; k <= CAPACITY; k++) id_at_row[k] = '0;
    burst_left = $urandom_range(1, 10);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (k = 0; k < DIRECTED_N; k++) begin
      typed_want = '{row: directed_steps[k].row, moved: directed_steps[k].moved,
                     status: directed_steps[k].status, count: directed_steps[k].count};
      send_beat(directed_steps[k].op, directed_steps[k].id, directed_steps[k].typed,
                typed_want);
    end

    // fill to capacity, churn against the full table, then run a remove-heavy mix
    while (live_rows < CAPACITY) issue_random(92, 4);
    repeat (80) issue_random(50, 25);
    repeat (250) issue_random(25, 60);
    start <= 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("dense_slot_table_swap_remove_unit verification clean");
    end else begin
      $display("dense_slot_table_swap_remove_unit verification failed");
    end
    $finish;
  end

endmodule
